/* rtl/core/dpsc_pkg.sv */
// Package for the DFT power spectrum core: sizes, fixed-point constants,
// command and status types, and the twiddle table built at elaboration.
// No dependencies; every other file of the core except dpsc_ram imports it.
package dpsc_pkg;

  // Frame and field sizes.
  localparam int FRAME_LEN    = 1024;
  localparam int SAMPLE_BITS  = 16;
  localparam int TWIDDLE_BITS = 16;
  localparam int BIN_BITS     = 9;
  localparam int POWER_BITS   = 52;
  localparam int SCALE_BITS   = 32;

  // Derived datapath widths.
  localparam int ADDR_BITS      = $clog2(FRAME_LEN);
  localparam int PROD_BITS      = SAMPLE_BITS + TWIDDLE_BITS;
  localparam int ACC_BITS       = PROD_BITS + ADDR_BITS;
  localparam int MAG_BITS       = ACC_BITS - TWIDDLE_BITS + 1;
  localparam int SQ_BITS        = 2 * MAG_BITS + 1;
  localparam int MUL_BITS       = 32;
  localparam int PHASE_SUM_BITS = ((ADDR_BITS > BIN_BITS) ? ADDR_BITS : BIN_BITS) + 1;

  // Fixed-point angle constants in Q30.
  localparam logic [63:0] PIQ     = 64'd3373259426;
  localparam logic [63:0] HALFPIQ = PIQ / 2;
  localparam logic [63:0] ONE_Q   = 64'd1 << 30;
  localparam logic [63:0] TW_AMP  = (64'd1 << (TWIDDLE_BITS - 1)) - 64'd1;

  // Operation of the shared finishing multiplier.
  typedef enum logic [2:0] {
    FIN_NONE,
    FIN_MAG,
    FIN_SQ_RE,
    FIN_SQ_IM,
    FIN_SUM,
    FIN_SCALE_LO,
    FIN_SCALE_HI
  } fin_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    start;
    logic    reduce;
    logic    issue;
    fin_op_t fin_op;
    logic    push;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic step_ge_len;
    logic last_issue;
    logic pipe_busy;
    logic out_free;
  } dp_status_t;

  // Entry [p][0] is cos, [p][1] is sin, both signed twiddle words.
  typedef logic [1:0][TWIDDLE_BITS-1:0]                 twiddle_pair_t;
  typedef logic [FRAME_LEN-1:0][1:0][TWIDDLE_BITS-1:0] twiddle_table_t;

  // Scale a Q30 value to the twiddle amplitude, round half away from zero, clamp.
  function automatic logic [TWIDDLE_BITS-1:0] to_twiddle(logic signed [63:0] v, logic neg);
    logic [63:0] mag;
    logic [63:0] q;
    logic        neg_f;
    neg_f = neg;
    if (v < 0) begin
      mag   = 64'(-v);
      neg_f = !neg;
    end else begin
      mag = 64'(v);
    end
    q = (mag * TW_AMP + (ONE_Q >> 1)) >> 30;
    if (q > TW_AMP) q = TW_AMP;
    if (neg_f) q = -q;
    return q[TWIDDLE_BITS-1:0];
  endfunction

  // One cos/sin pair from folded Taylor series, each term truncated in Q30.
  function automatic twiddle_pair_t twiddle_entry(int unsigned p);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        ts;
    logic [63:0]        tc;
    logic signed [63:0] ss;
    logic signed [63:0] cs;
    logic               sneg;
    logic               cneg;
    twiddle_pair_t      pair;
    x    = (64'd2 * PIQ * 64'(p)) / FRAME_LEN;
    sneg = 1'b0;
    cneg = 1'b0;
    if (x > PIQ) begin
      x    = x - PIQ;
      sneg = 1'b1;
      cneg = 1'b1;
    end
    if (x > HALFPIQ) begin
      x    = PIQ - x;
      cneg = !cneg;
    end
    x2 = (x * x) >> 30;
    ts = x;
    ss = $signed(x);
    tc = ONE_Q;
    cs = $signed(ONE_Q);
    for (int i = 1; i <= 8; i++) begin
      ts = ((ts * x2) >> 30) / 64'((2 * i) * (2 * i + 1));
      tc = ((tc * x2) >> 30) / 64'((2 * i - 1) * (2 * i));
      if (i % 2 == 1) begin
        ss = ss - $signed(ts);
        cs = cs - $signed(tc);
      end else begin
        ss = ss + $signed(ts);
        cs = cs + $signed(tc);
      end
    end
    pair[0] = to_twiddle(cs, cneg);
    pair[1] = to_twiddle(ss, sneg);
    return pair;
  endfunction

  // Whole table, evaluated once at elaboration.
  function automatic twiddle_table_t build_twiddle_table();
    twiddle_table_t tbl;
    for (int unsigned p = 0; p < FRAME_LEN; p++) begin
      tbl[p] = twiddle_entry(p);
    end
    return tbl;
  endfunction

  localparam twiddle_table_t TWIDDLE_TABLE = build_twiddle_table();

endpackage

/* rtl/core/dpsc_in_if.sv */
// Input channel of the DFT power spectrum core: valid/ready plus one request word.
// Depends on dpsc_pkg for the field widths.
interface dpsc_in_if;
  import dpsc_pkg::*;

  logic                          valid;
  logic                          ready;
  logic                          action;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic [BIN_BITS-1:0]           bin_index;

  modport source (output valid, output action, output sample, output bin_index,
                  input ready);
  modport sink   (input valid, input action, input sample, input bin_index,
                  output ready);
endinterface

/* rtl/core/dpsc_out_if.sv */
// Result channel of the DFT power spectrum core: valid/ready plus one result word.
// Depends on dpsc_pkg for the field widths.
interface dpsc_out_if;
  import dpsc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [BIN_BITS-1:0]   bin_out;
  logic [POWER_BITS-1:0] power;
  logic                  frame_complete;

  modport source (output valid, output bin_out, output power, output frame_complete,
                  input ready);
  modport sink   (input valid, input bin_out, input power, input frame_complete,
                  output ready);
endinterface

/* rtl/core/dpsc_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
module dpsc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write when enabled; the address is read on every clock, and the read data is registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* rtl/core/dpsc_twiddle_rom.sv */
// Cosine and sine twiddle ROM with registered read.
// Depends on dpsc_pkg for the table built at elaboration.
module dpsc_twiddle_rom (
  input  logic                                  clk,
  input  logic [dpsc_pkg::ADDR_BITS-1:0]        addr,
  output logic signed [dpsc_pkg::TWIDDLE_BITS-1:0] cos_val,
  output logic signed [dpsc_pkg::TWIDDLE_BITS-1:0] sin_val
);
  import dpsc_pkg::*;

  // One lookup per cycle for the phase presented.
  always_ff @(posedge clk) begin
    cos_val <= $signed(TWIDDLE_TABLE[addr][0]);
    sin_val <= $signed(TWIDDLE_TABLE[addr][1]);
  end

endmodule

/* rtl/core/dpsc_ctrl.sv */
// Controller of the DFT power spectrum core: sequences loads, the per-bin
// correlation sweep, the squaring and scaling steps, and the result hand-off.
// Depends on dpsc_pkg for the command and status types.
module dpsc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_action,
  output logic                 in_ready,
  input  dpsc_pkg::dp_status_t status,
  output dpsc_pkg::dp_cmd_t    cmd
);
  import dpsc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_REDUCE,
    S_ISSUE,
    S_DRAIN,
    S_MAG,
    S_SQ_RE,
    S_SQ_IM,
    S_SUM,
    S_SCALE_LO,
    S_SCALE_HI,
    S_PUSH
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next state and the command for the current cycle.
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.fin_op = FIN_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && !in_action) begin
          cmd.load = 1'b1;
        end else if (in_valid && in_action) begin
          cmd.start = 1'b1;
          state_nxt = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (status.step_ge_len) begin
          cmd.reduce = 1'b1;
        end else begin
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.issue = 1'b1;
        if (status.last_issue) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!status.pipe_busy) begin
          state_nxt = S_MAG;
        end
      end
      S_MAG: begin
        cmd.fin_op = FIN_MAG;
        state_nxt  = S_SQ_RE;
      end
      S_SQ_RE: begin
        cmd.fin_op = FIN_SQ_RE;
        state_nxt  = S_SQ_IM;
      end
      S_SQ_IM: begin
        cmd.fin_op = FIN_SQ_IM;
        state_nxt  = S_SUM;
      end
      S_SUM: begin
        cmd.fin_op = FIN_SUM;
        state_nxt  = S_SCALE_LO;
      end
      S_SCALE_LO: begin
        cmd.fin_op = FIN_SCALE_LO;
        state_nxt  = S_SCALE_HI;
      end
      S_SCALE_HI: begin
        cmd.fin_op = FIN_SCALE_HI;
        state_nxt  = S_PUSH;
      end
      S_PUSH: begin
        if (status.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // A new word is taken only between bin computations.
  assign in_ready = (state_r == S_IDLE);

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/core/dpsc_datapath.sv */
// Datapath of the DFT power spectrum core: sample store, load counter,
// twiddle ROM, dual multiply-accumulate, finishing multiplier and result register.
// Depends on dpsc_pkg, dpsc_ram and dpsc_twiddle_rom.
module dpsc_datapath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  dpsc_pkg::dp_cmd_t                     cmd,
  output dpsc_pkg::dp_status_t                  status,
  input  logic signed [dpsc_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic [dpsc_pkg::BIN_BITS-1:0]         in_bin_index,
  input  logic                                  cfg_we,
  input  logic [dpsc_pkg::SCALE_BITS-1:0]       cfg_wdata,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic [dpsc_pkg::BIN_BITS-1:0]         out_bin_out,
  output logic [dpsc_pkg::POWER_BITS-1:0]       out_power,
  output logic                                  out_frame_complete
);
  import dpsc_pkg::*;

  // Frame bookkeeping and configuration.
  logic [ADDR_BITS-1:0]  load_count_r;
  logic                  frame_full_r;
  logic [SCALE_BITS-1:0] power_scale_r;

  // Per-request registers.
  logic [BIN_BITS-1:0]  bin_r;
  logic                 fc_r;
  logic [BIN_BITS-1:0]  step_r;
  logic [ADDR_BITS-1:0] n_r;
  logic [ADDR_BITS-1:0] phase_r;
  logic [ADDR_BITS-1:0] phase_nxt;
  logic [PHASE_SUM_BITS-1:0] phase_sum;

  // Correlation pipeline.
  logic                          rd_v_r;
  logic                          mul_v_r;
  logic [SAMPLE_BITS-1:0]        ram_rdata;
  logic [ADDR_BITS-1:0]          ram_addr;
  logic signed [TWIDDLE_BITS-1:0] cos_val;
  logic signed [TWIDDLE_BITS-1:0] sin_val;
  logic signed [PROD_BITS-1:0]   prod_re_r;
  logic signed [PROD_BITS-1:0]   prod_im_r;
  logic signed [ACC_BITS-1:0]    acc_re_r;
  logic signed [ACC_BITS-1:0]    acc_im_r;

  // Finishing steps.
  logic [ACC_BITS-1:0]     abs_re;
  logic [ACC_BITS-1:0]     abs_im;
  logic [ACC_BITS-1:0]     rnd_re;
  logic [ACC_BITS-1:0]     rnd_im;
  logic [MAG_BITS-1:0]     re_mag_r;
  logic [MAG_BITS-1:0]     im_mag_r;
  logic [MUL_BITS-1:0]     mul_a;
  logic [MUL_BITS-1:0]     mul_b;
  logic [2*MUL_BITS-1:0]   mul_p;
  logic [2*MUL_BITS-1:0]   prod_r;
  logic [SQ_BITS-1:0]      sq_r;
  logic [MUL_BITS-1:0]     part_r;
  logic [2*MUL_BITS:0]     final_sum;
  logic [POWER_BITS-1:0]   power_sat;

  // Result register.
  logic                  out_valid_r;
  logic [BIN_BITS-1:0]   bin_out_r;
  logic [POWER_BITS-1:0] power_r;
  logic                  frame_complete_r;

  // Sample store: written by loads, read by the sweep.
  assign ram_addr = cmd.load ? load_count_r : n_r;

  dpsc_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(FRAME_LEN)
  ) u_sample_ram (
    .clk   (clk),
    .we    (cmd.load),
    .addr  (ram_addr),
    .wdata (in_sample),
    .rdata (ram_rdata)
  );

  dpsc_twiddle_rom u_twiddle_rom (
    .clk     (clk),
    .addr    (phase_r),
    .cos_val (cos_val),
    .sin_val (sin_val)
  );

  // Load counter, frame flag and scale register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_count_r  <= '0;
      frame_full_r  <= 1'b0;
      power_scale_r <= '1;
    end else begin
      if (cfg_we) begin
        power_scale_r <= cfg_wdata;
      end
      if (cmd.load) begin
        if (load_count_r == ADDR_BITS'(FRAME_LEN - 1)) begin
          load_count_r <= '0;
          frame_full_r <= 1'b1;
        end else begin
          load_count_r <= load_count_r + 1'b1;
          if (load_count_r == '0) begin
            frame_full_r <= 1'b0;
          end
        end
      end
    end
  end

  // Phase advances by the bin step modulo the frame length.
  always_comb begin
    phase_sum = PHASE_SUM_BITS'(phase_r) + PHASE_SUM_BITS'(step_r);
    if (phase_sum >= PHASE_SUM_BITS'(FRAME_LEN)) begin
      phase_sum = phase_sum - PHASE_SUM_BITS'(FRAME_LEN);
    end
    phase_nxt = phase_sum[ADDR_BITS-1:0];
  end

  // Request setup, step reduction and sweep counters.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      bin_r   <= in_bin_index;
      fc_r    <= frame_full_r;
      step_r  <= in_bin_index;
      n_r     <= '0;
      phase_r <= '0;
    end else if (cmd.reduce) begin
      step_r <= step_r - BIN_BITS'(FRAME_LEN);
    end else if (cmd.issue) begin
      n_r     <= n_r + 1'b1;
      phase_r <= phase_nxt;
    end
  end

  // Valid bits of the read and multiply stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r  <= 1'b0;
      mul_v_r <= 1'b0;
    end else begin
      rd_v_r  <= cmd.issue;
      mul_v_r <= rd_v_r;
    end
  end

  // Products of sample and twiddle, then exact accumulation.
  always_ff @(posedge clk) begin
    prod_re_r <= $signed(ram_rdata) * cos_val;
    prod_im_r <= $signed(ram_rdata) * sin_val;
    if (cmd.start) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else if (mul_v_r) begin
      acc_re_r <= acc_re_r + ACC_BITS'(prod_re_r);
      acc_im_r <= acc_im_r + ACC_BITS'(prod_im_r);
    end
  end

  // Magnitudes rounded half away from zero to the sample scale.
  always_comb begin
    abs_re = acc_re_r[ACC_BITS-1] ? ACC_BITS'(-acc_re_r) : ACC_BITS'(acc_re_r);
    abs_im = acc_im_r[ACC_BITS-1] ? ACC_BITS'(-acc_im_r) : ACC_BITS'(acc_im_r);
    rnd_re = abs_re + (ACC_BITS'(1) << (TWIDDLE_BITS - 2));
    rnd_im = abs_im + (ACC_BITS'(1) << (TWIDDLE_BITS - 2));
  end

  // Operand selection of the shared finishing multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.fin_op)
      FIN_SQ_RE: begin
        mul_a = MUL_BITS'(re_mag_r);
        mul_b = MUL_BITS'(re_mag_r);
      end
      FIN_SQ_IM: begin
        mul_a = MUL_BITS'(im_mag_r);
        mul_b = MUL_BITS'(im_mag_r);
      end
      FIN_SCALE_LO: begin
        mul_a = sq_r[MUL_BITS-1:0];
        mul_b = power_scale_r;
      end
      FIN_SCALE_HI: begin
        mul_a = MUL_BITS'(sq_r[SQ_BITS-1:MUL_BITS]);
        mul_b = power_scale_r;
      end
      FIN_NONE, FIN_MAG, FIN_SUM: begin
        mul_a = '0;
        mul_b = '0;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Squaring, sum of squares and the two partial products of the scaling.
  always_ff @(posedge clk) begin
    unique case (cmd.fin_op)
      FIN_MAG: begin
        re_mag_r <= rnd_re[ACC_BITS-1:TWIDDLE_BITS-1];
        im_mag_r <= rnd_im[ACC_BITS-1:TWIDDLE_BITS-1];
      end
      FIN_SQ_RE: begin
        prod_r <= mul_p;
      end
      FIN_SQ_IM: begin
        prod_r <= mul_p;
        sq_r   <= SQ_BITS'(prod_r);
      end
      FIN_SUM: begin
        sq_r <= sq_r + SQ_BITS'(prod_r);
      end
      FIN_SCALE_LO: begin
        prod_r <= mul_p;
      end
      FIN_SCALE_HI: begin
        prod_r <= mul_p;
        part_r <= prod_r[2*MUL_BITS-1:MUL_BITS];
      end
      FIN_NONE: begin
      end
      default: begin
      end
    endcase
  end

  // High partial product plus the carried upper half of the low one, saturated.
  always_comb begin
    final_sum = (2*MUL_BITS+1)'(prod_r) + (2*MUL_BITS+1)'(part_r);
    if (final_sum[2*MUL_BITS:POWER_BITS] != '0) begin
      power_sat = '1;
    end else begin
      power_sat = final_sum[POWER_BITS-1:0];
    end
  end

  // Result register: holds one word until the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      bin_out_r        <= bin_r;
      power_r          <= power_sat;
      frame_complete_r <= fc_r;
    end
  end

  // Status back to the controller.
  always_comb begin
    status.step_ge_len = (32'(step_r) >= 32'(FRAME_LEN));
    status.last_issue  = (n_r == ADDR_BITS'(FRAME_LEN - 1));
    status.pipe_busy   = rd_v_r || mul_v_r;
    status.out_free    = !out_valid_r || out_ready;
  end

  assign out_valid          = out_valid_r;
  assign out_bin_out        = bin_out_r;
  assign out_power          = power_r;
  assign out_frame_complete = frame_complete_r;

endmodule

/* rtl/core/dft_power_spectrum_core.sv */
// Top level of the DFT power spectrum core: controller plus datapath.
// Depends on dpsc_pkg, dpsc_in_if, dpsc_out_if, dpsc_ctrl and dpsc_datapath.
//
//   Channel   Direction  Handshake        Word
//   in_ch     input      valid / ready    action, sample, bin_index
//   out_ch    output     valid / ready    bin_out, power, frame_complete
//   cfg_*     input      write enable     power_scale (32 bits)
//
// A bin request holds the core until its result is pushed: the sweep feeds one
// stored sample and one twiddle pair per cycle into two multiply-accumulators,
// then one shared 32x32 multiplier squares and scales in six steps. Reset is
// synchronous and active low and clears the load counter, the frame flag, the
// scale (to all ones) and the valid bit of the result register.
// A finished word waits in the result register; a stalled sink holds the core
// only when the next result is ready to replace it.
module dft_power_spectrum_core (
  input  logic                            clk,
  input  logic                            rst_n,
  dpsc_in_if.sink                         in_ch,
  dpsc_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [dpsc_pkg::SCALE_BITS-1:0] cfg_wdata
);
  import dpsc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  dpsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  dpsc_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_sample          (in_ch.sample),
    .in_bin_index       (in_ch.bin_index),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .out_ready          (out_ch.ready),
    .out_valid          (out_ch.valid),
    .out_bin_out        (out_ch.bin_out),
    .out_power          (out_ch.power),
    .out_frame_complete (out_ch.frame_complete)
  );

endmodule
